>>> src/indexed_list_insert_erase_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list insert/erase unit
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_ERASE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_ERASE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds in a cycle -> consequent holds in the same cycle
`define ILIE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ilie check failed");
// antecedent holds in a cycle -> consequent holds in the next cycle
`define ILIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ilie check failed");
`else
`define ILIE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ILIE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/ilie_pkg.sv
// ----------------------------------------------------------------------------
// ilie_pkg
// Types and constants shared by the indexed list insert/erase unit.
// ----------------------------------------------------------------------------
package ilie_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_POP    = 3'd1,
      OP_ERASE  = 3'd2,
      OP_INSERT = 3'd3,
      OP_READ   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_APPEND,
      ACT_POP,
      ACT_CLEAR,
      ACT_READ,
      ACT_ERASE,
      ACT_INSERT
   } act_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ERASE,
      S_INSERT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic take;
      logic step;
      logic finish_erase;
      logic finish_insert;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      act_type act;
      logic    sweep_done;
   } dp_status_type;

endpackage

>>> src/ilie_ram.sv
// ----------------------------------------------------------------------------
// ilie_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ilie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ilie_dpath.sv
// ----------------------------------------------------------------------------
// ilie_dpath
// List storage, entry count, shift sweep pipeline and result registers.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_erase_unit_macros.svh"

module ilie_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ilie_pkg::OP_W-1:0]            req_operation,
   input  logic [ilie_pkg::POS_W-1:0]           req_position,
   input  logic signed [ilie_pkg::DATA_W-1:0]   req_value,
   input  ilie_pkg::ctrl_cmd_type               cmd,
   output ilie_pkg::dp_status_type              stat,
   output logic signed [ilie_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [ilie_pkg::CNT_W-1:0]           rsp_count,
   output logic                                 rsp_is_empty,
   output logic [ilie_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int IDX_W  = ilie_pkg::IDX_W;
   localparam int CNT_W  = ilie_pkg::CNT_W;
   localparam int CMP_W  = ilie_pkg::CMP_W;
   localparam int DATA_W = ilie_pkg::DATA_W;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cursor_ff, cursor_in;
   logic                     wr_valid_ff, wr_valid_in;
   logic [IDX_W-1:0]         wr_addr_ff, wr_addr_in;
   ilie_pkg::act_type        act_ff, act_in;
   ilie_pkg::status_type     status_ff, status_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [DATA_W-1:0]        val_ff, val_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   ilie_pkg::status_type     rsp_status_ff, rsp_status_in;

   ilie_pkg::act_type        act_dec;
   ilie_pkg::status_type     status_dec;
   logic                     in_range;
   logic                     full;
   logic                     more;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [DATA_W-1:0]        ram_wdata;
   logic                     ram_re;
   logic [IDX_W-1:0]         ram_raddr;
   logic [DATA_W-1:0]        ram_q;

   ilie_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ilie_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // decode the incoming request against the current count
   always_comb begin
      in_range   = CMP_W'(req_position) < CMP_W'(count_ff);
      full       = count_ff == CNT_W'(ilie_pkg::CAPACITY);
      act_dec    = ilie_pkg::ACT_NONE;
      status_dec = ilie_pkg::ST_DONE;
      case (ilie_pkg::op_type'(req_operation))
         ilie_pkg::OP_APPEND: begin
            if (full) status_dec = ilie_pkg::ST_FULL;
            else act_dec = ilie_pkg::ACT_APPEND;
         end
         ilie_pkg::OP_POP: begin
            if (count_ff == '0) status_dec = ilie_pkg::ST_IGNORED;
            else act_dec = ilie_pkg::ACT_POP;
         end
         ilie_pkg::OP_ERASE: begin
            if (!in_range) status_dec = ilie_pkg::ST_IGNORED;
            else act_dec = ilie_pkg::ACT_ERASE;
         end
         ilie_pkg::OP_INSERT: begin
            if (!in_range) status_dec = ilie_pkg::ST_IGNORED;
            else if (full) status_dec = ilie_pkg::ST_FULL;
            else act_dec = ilie_pkg::ACT_INSERT;
         end
         ilie_pkg::OP_READ: begin
            if (!in_range) status_dec = ilie_pkg::ST_IGNORED;
            else act_dec = ilie_pkg::ACT_READ;
         end
         ilie_pkg::OP_CLEAR: begin
            act_dec = ilie_pkg::ACT_CLEAR;
         end
         default: begin
            status_dec = ilie_pkg::ST_IGNORED;
         end
      endcase
   end

   // erase walks up from pos+1, insert walks down to pos
   assign more = (act_ff == ilie_pkg::ACT_ERASE) ? (cursor_ff < count_ff)
                                                 : (cursor_ff > CNT_W'(pos_ff));

   always_comb begin
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      wr_valid_in   = 1'b0;
      wr_addr_in    = wr_addr_ff;
      act_in        = act_ff;
      status_in     = status_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = wr_valid_ff;
      ram_waddr     = wr_addr_ff;
      ram_wdata     = ram_q;
      ram_re        = 1'b0;
      ram_raddr     = IDX_W'(cursor_ff);

      if (cmd.take) begin
         act_in    = act_dec;
         status_in = status_dec;
         pos_in    = IDX_W'(req_position);
         val_in    = req_value;
         case (act_dec)
            ilie_pkg::ACT_APPEND: begin
               ram_we    = 1'b1;
               ram_waddr = IDX_W'(count_ff);
               ram_wdata = req_value;
               count_in  = count_ff + CNT_W'(1);
            end
            ilie_pkg::ACT_POP: begin
               count_in = count_ff - CNT_W'(1);
            end
            ilie_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            ilie_pkg::ACT_READ: begin
               ram_re    = 1'b1;
               ram_raddr = IDX_W'(req_position);
            end
            ilie_pkg::ACT_ERASE: begin
               cursor_in = CNT_W'(req_position) + CNT_W'(1);
            end
            ilie_pkg::ACT_INSERT: begin
               cursor_in = count_ff;
            end
            default: begin
            end
         endcase
      end

      // one entry per cycle: read here, written back in the next cycle
      if (cmd.step && more) begin
         ram_re      = 1'b1;
         wr_valid_in = 1'b1;
         if (act_ff == ilie_pkg::ACT_ERASE) begin
            ram_raddr  = IDX_W'(cursor_ff);
            wr_addr_in = IDX_W'(cursor_ff - CNT_W'(1));
            cursor_in  = cursor_ff + CNT_W'(1);
         end else begin
            ram_raddr  = IDX_W'(cursor_ff - CNT_W'(1));
            wr_addr_in = IDX_W'(cursor_ff);
            cursor_in  = cursor_ff - CNT_W'(1);
         end
      end

      if (cmd.finish_erase) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.finish_insert) begin
         ram_we    = 1'b1;
         ram_waddr = pos_ff;
         ram_wdata = val_ff;
         count_in  = count_ff + CNT_W'(1);
      end

      if (cmd.load_rsp) begin
         rsp_data_in   = (act_ff == ilie_pkg::ACT_READ) ? ram_q : '0;
         rsp_count_in  = count_ff;
         rsp_empty_in  = count_ff == '0;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         wr_valid_ff <= 1'b0;
         act_ff      <= ilie_pkg::ACT_NONE;
      end else begin
         count_ff    <= count_in;
         wr_valid_ff <= wr_valid_in;
         act_ff      <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff     <= cursor_in;
      wr_addr_ff    <= wr_addr_in;
      status_ff     <= status_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign stat.act        = act_dec;
   assign stat.sweep_done = !more && !wr_valid_ff;

   assign rsp_read_data = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

   `ILIE_ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(ilie_pkg::CAPACITY))
   `ILIE_ASSERT_IMPLY(a_take_no_pending, clock, reset, cmd.take, !wr_valid_ff)
   `ILIE_ASSERT_IMPLY(a_insert_room, clock, reset, cmd.finish_insert, !full && !wr_valid_ff)
   `ILIE_ASSERT_NEXT(a_erase_shrinks, clock, reset, cmd.finish_erase,
                     count_ff == $past(count_ff) - CNT_W'(1))

endmodule

>>> src/ilie_ctrl.sv
// ----------------------------------------------------------------------------
// ilie_ctrl
// Sequencer: takes a request, runs the shift sweep, hands the result over.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_erase_unit_macros.svh"

module ilie_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  ilie_pkg::dp_status_type       stat,
   output ilie_pkg::ctrl_cmd_type        cmd
);

   ilie_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilie_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ilie_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               case (stat.act)
                  ilie_pkg::ACT_ERASE:  state_in = ilie_pkg::S_ERASE;
                  ilie_pkg::ACT_INSERT: state_in = ilie_pkg::S_INSERT;
                  default:              state_in = ilie_pkg::S_RESULT;
               endcase
            end
         end
         ilie_pkg::S_ERASE: begin
            if (stat.sweep_done) begin
               cmd.finish_erase = 1'b1;
               state_in         = ilie_pkg::S_RESULT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ilie_pkg::S_INSERT: begin
            if (stat.sweep_done) begin
               cmd.finish_insert = 1'b1;
               state_in          = ilie_pkg::S_RESULT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ilie_pkg::S_RESULT: begin
            // hold until the output register can take the beat
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ilie_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ilie_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ILIE_ASSERT_NEXT(a_load_returns_idle, clock, reset, cmd.load_rsp,
                     state_ff == ilie_pkg::S_IDLE && rsp_valid_ff)
   `ILIE_ASSERT_IMPLY(a_one_cmd, clock, reset, 1'b1,
                      $onehot0({cmd.take, cmd.step, cmd.finish_erase, cmd.finish_insert,
                                cmd.load_rsp}))
   `ILIE_ASSERT_NEXT(a_take_leaves_idle, clock, reset, cmd.take,
                     state_ff != ilie_pkg::S_IDLE)

endmodule

>>> src/indexed_list_insert_erase_unit.sv
// Flow: append, remove last, read, clear and ignored requests go straight to the result;
// erase and insert first run a shift sweep over the entries that move, then give the result.
// Throughput: one request at a time, the next taken as the beat goes out; the sweep through
// the list RAM moves one entry per cycle, and a stalled result holds the unit until the
// output register can take the beat.
// Reset: synchronous, active high; empties the list; stored entries are left as they are.
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_unit
// Ordered list of 32-bit integers with append, remove last, erase, insert,
// read and clear, one result beat per request.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ilie_pkg::OP_W-1:0]            req_operation,
   input  logic [ilie_pkg::POS_W-1:0]           req_position,
   input  logic signed [ilie_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ilie_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [ilie_pkg::CNT_W-1:0]           rsp_count,
   output logic                                 rsp_is_empty,
   output logic [ilie_pkg::STATUS_W-1:0]        rsp_status
);

   ilie_pkg::ctrl_cmd_type  cmd;
   ilie_pkg::dp_status_type stat;

   ilie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ilie_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_value     (req_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_read_data (rsp_read_data),
      .rsp_count     (rsp_count),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_status    (rsp_status)
   );

endmodule
